[design/rbps_pkg.sv]
// ----------------------------------------------------------------------------
// rbps_pkg
// types, codes and constant tables for receive bandwidth profile selection
// ----------------------------------------------------------------------------
package rbps_pkg;

    localparam logic [24:0] XTAL_HZ         = 25'd26000000;
    localparam logic [19:0] GUARD_RESET     = 20'd50000;
    localparam logic [19:0] AGC_LIMIT_RESET = 20'd101562;

    // modulation format, bits 6..4 of the modulation register
    localparam logic [2:0] FMT_2FSK = 3'd0;
    localparam logic [2:0] FMT_GFSK = 3'd1;
    localparam logic [2:0] FMT_OOK  = 3'd3;

    localparam logic [3:0] FILTER_OOK_CODE = 4'hA;
    localparam logic [7:0] AGC_KEEP_MASK   = 8'hF8;
    localparam logic [7:0] AGC_TIGHT_BITS  = 8'h03;
    localparam logic [7:0] AGC_OOK_VALUE   = 8'h04;

    // configuration register indexes
    localparam logic CFG_GUARD     = 1'b0;
    localparam logic CFG_AGC_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_NARROWED = 2'd0,
        ST_SUITABLE = 2'd1,
        ST_OOK      = 2'd2,
        ST_KEPT     = 2'd3
    } t_status;

    typedef logic [19:0] t_hz;
    typedef t_hz         t_filter_table [16];
    typedef logic [18:0] t_dev_table [64];

    // filter bandwidth per code {exponent, mantissa}: xtal / (8 * (4 + m) * 2^e)
    localparam t_filter_table FILTER_HZ = '{
        20'd812500, 20'd650000, 20'd541666, 20'd464285,
        20'd406250, 20'd325000, 20'd270833, 20'd232142,
        20'd203125, 20'd162500, 20'd135416, 20'd116071,
        20'd101562, 20'd81250,  20'd67708,  20'd58035
    };

    // rounded deviation per {exponent, mantissa}, built at elaboration
    function automatic t_dev_table build_dev_table();
        t_dev_table  tab;
        logic [63:0] n;
        logic [2:0]  m;
        logic [2:0]  e;
        for (int i = 0; i < 64; i++) begin
            m      = 3'(i);
            e      = 3'(i >> 3);
            n      = (64'(XTAL_HZ) * (64'd8 + 64'(m))) << e;
            tab[i] = 19'((n + 64'd65536) >> 17);
        end
        return tab;
    endfunction

    localparam t_dev_table DEV_HZ = build_dev_table();

    typedef struct packed {
        logic [7:0] modem_cfg2;
        logic [7:0] modem_cfg3;
        logic [7:0] modem_cfg4;
        logic [7:0] deviation_reg;
        logic [7:0] agc_ctrl2;
        logic       agc_present;
    } t_in_item;

    typedef struct packed {
        t_status     profile_status;
        logic [7:0]  new_modem_cfg4;
        logic [7:0]  new_agc_ctrl2;
        logic [19:0] rx_filter_hz;
        logic [20:0] data_rate_hz;
        logic [18:0] deviation_hz;
    } t_out_item;

endpackage

[design/radio_bandwidth_profile_select.sv]
// ----------------------------------------------------------------------------
// radio_bandwidth_profile_select: receive filter and agc profile per preset
// input register, then result register; one transfer per cycle while i_stall is low
// rate set by a single pass of rate multiply, add and 16 parallel compares
// reset (synchronous, active low) empties both stages and restores config
// ----------------------------------------------------------------------------
module radio_bandwidth_profile_select
    import rbps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);

    // configuration registers
    logic [19:0] r_guard;
    logic [19:0] r_agc_limit;

    // input stage
    logic        r_in_valid;
    t_in_item    r_in;

    // result stage
    logic        r_out_valid;
    t_out_item   r_out;

    logic        adv_out;
    logic        load_in;
    logic        n_in_valid;

    // datapath
    logic [2:0]  fmt;
    logic [33:0] rate_prod;
    logic [48:0] rate_shift;
    logic [48:0] rate_round;
    logic [20:0] rate;
    logic [18:0] dev;
    logic [21:0] need;
    logic [3:0]  pick_code;
    t_hz         pick_hz;
    t_hz         bw_orig;
    t_out_item   n_out;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard     <= GUARD_RESET;
            r_agc_limit <= AGC_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GUARD:     r_guard     <= i_cfg_data;
                CFG_AGC_LIMIT: r_agc_limit <= i_cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------ handshake
    // result register frees when empty or when its transfer completes;
    // the input register holds one item while a result waits
    assign adv_out  = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !adv_out;
    assign load_in  = i_valid && !o_stall;
    assign n_in_valid = load_in || (r_in_valid && !adv_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in <= i_item;
        end
        if (adv_out && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------- datapath
    assign fmt = r_in.modem_cfg2[6:4];

    // data rate: round((256 + mantissa) * xtal * 2^e / 2^28)
    assign rate_prod  = 34'({1'b1, r_in.modem_cfg3}) * 34'(XTAL_HZ);
    assign rate_shift = 49'(rate_prod) << r_in.modem_cfg4[3:0];
    assign rate_round = rate_shift + (49'd1 << 27);
    assign rate       = rate_round[48:28];

    // deviation straight from the constant table, bits 7 and 3 unused
    assign dev = DEV_HZ[{r_in.deviation_reg[6:4], r_in.deviation_reg[2:0]}];

    assign need = 22'(rate) + 22'({dev, 1'b0}) + 22'(r_guard);

    assign bw_orig = FILTER_HZ[r_in.modem_cfg4[7:4]];

    // narrowest covering code wins; widest filter when none covers
    always_comb begin
        pick_code = 4'd0;
        pick_hz   = FILTER_HZ[0];
        for (int c = 0; c < 16; c++) begin
            if (22'(FILTER_HZ[c]) >= need) begin
                pick_code = 4'(c);
                pick_hz   = FILTER_HZ[c];
            end
        end
    end

    always_comb begin
        n_out.profile_status  = ST_KEPT;
        n_out.new_modem_cfg4  = r_in.modem_cfg4;
        n_out.new_agc_ctrl2   = r_in.agc_ctrl2;
        n_out.rx_filter_hz    = bw_orig;
        n_out.data_rate_hz    = '0;
        n_out.deviation_hz    = '0;
        priority if (fmt == FMT_OOK) begin
            n_out.profile_status  = ST_OOK;
            n_out.new_modem_cfg4  = {FILTER_OOK_CODE, r_in.modem_cfg4[3:0]};
            n_out.new_agc_ctrl2   = AGC_OOK_VALUE;
            n_out.rx_filter_hz    = FILTER_HZ[FILTER_OOK_CODE];
        end else if (fmt == FMT_2FSK || fmt == FMT_GFSK) begin
            n_out.data_rate_hz = rate;
            n_out.deviation_hz = dev;
            if (pick_hz >= bw_orig) begin
                n_out.profile_status = ST_SUITABLE;
            end else begin
                n_out.profile_status  = ST_NARROWED;
                n_out.new_modem_cfg4  = {pick_code, r_in.modem_cfg4[3:0]};
                n_out.rx_filter_hz    = pick_hz;
                // tighter agc target for narrow filters
                if (r_in.agc_present && pick_hz <= r_agc_limit) begin
                    n_out.new_agc_ctrl2 = (r_in.agc_ctrl2 & AGC_KEEP_MASK) | AGC_TIGHT_BITS;
                end
            end
        end else begin
            n_out.profile_status = ST_KEPT;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // ----------------------------------------------------------- assertions
    // ook result always carries the fixed filter and agc value
    a_ook_profile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.profile_status == ST_OOK |->
            o_item.new_agc_ctrl2 == AGC_OOK_VALUE &&
            o_item.rx_filter_hz == FILTER_HZ[FILTER_OOK_CODE])
        else $error("ook profile fields wrong");

    // only fm results report a rate or a deviation
    a_no_fm_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.profile_status == ST_OOK ||
                    o_item.profile_status == ST_KEPT) |->
            o_item.data_rate_hz == '0 && o_item.deviation_hz == '0)
        else $error("rate or deviation reported for non-fm item");

    // a held input item is neither dropped nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv_out |=> r_in_valid && $stable(r_in))
        else $error("input stage lost a held item");

    // narrowing always lowers the bandwidth below the original filter
    a_narrowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && adv_out && n_out.profile_status == ST_NARROWED |->
            n_out.rx_filter_hz < bw_orig)
        else $error("narrowed profile not narrower");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: receive bandwidth profile selection testbench
// walks a short table of preset bytes, then random presets through several
// guard and agc limit settings; every result is checked field by field against
// its typed result or an in-house predictor, random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rbps_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASES           = 6;
    localparam int PRESETS_PER_PHASE = 190;
    localparam int HOLD_CYCLES      = 150;
    localparam int REPORT_CAP       = 100;

    // one row of the directed table; typed rows carry their own result
    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item result;
    } t_dir_row;

    localparam t_out_item NO_RESULT = '{ST_NARROWED, 8'h00, 8'h00, 20'd0, 21'd0, 19'd0};

    // cfg2, cfg3, cfg4, deviation, agc_ctrl2, agc_present
    localparam t_dir_row DIR_TABLE [20] = '{
        // on-off keying: filter forced to the 135 kHz code, agc set
        '{'{8'h30, 8'h00, 8'h5F, 8'h00, 8'h00, 1'b0}, 1'b1,
          '{ST_OOK, 8'hAF, 8'h04, 20'd135416, 21'd0, 19'd0}},
        '{'{8'hB7, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 1'b1}, 1'b1,
          '{ST_OOK, 8'hA0, 8'h04, 20'd135416, 21'd0, 19'd0}},
        // unsupported formats pass straight through
        '{'{8'h20, 8'h12, 8'h00, 8'h34, 8'h5A, 1'b1}, 1'b1,
          '{ST_KEPT, 8'h00, 8'h5A, 20'd812500, 21'd0, 19'd0}},
        '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hA5, 1'b0}, 1'b1,
          '{ST_KEPT, 8'hFF, 8'hA5, 20'd58035, 21'd0, 19'd0}},
        '{'{8'h40, 8'h00, 8'h90, 8'h00, 8'h00, 1'b1}, 1'b1,
          '{ST_KEPT, 8'h90, 8'h00, 20'd162500, 21'd0, 19'd0}},
        '{'{8'h5C, 8'h3C, 8'h6A, 8'h21, 8'h99, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h60, 8'hC3, 8'h2B, 8'h56, 8'h66, 1'b0}, 1'b0, NO_RESULT},
        // fm: all-zero preset, narrowed with no agc entry
        '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_RESULT},
        // fm: narrowed far enough to tighten the agc
        '{'{8'h00, 8'h00, 8'h05, 8'h00, 8'hF0, 1'b1}, 1'b0, NO_RESULT},
        // fm: need beyond the widest filter, falls back to it
        '{'{8'h10, 8'hFF, 8'h0F, 8'h77, 8'hFF, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1}, 1'b0, NO_RESULT},
        // deviation bits 7 and 3 set, must be ignored
        '{'{8'h00, 8'h80, 8'h34, 8'h8B, 8'h3C, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h00, 8'h00, 8'h00, 8'h77, 8'h00, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h8F, 8'h7F, 8'h88, 8'h25, 8'h81, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h00, 8'h00, 8'h0F, 8'h00, 8'h00, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h10, 8'h55, 8'hC7, 8'h42, 8'hE6, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h10, 8'hAA, 8'h4A, 8'h33, 8'h17, 1'b0}, 1'b0, NO_RESULT},
        // narrowest filter already in place
        '{'{8'h00, 8'h00, 8'hF0, 8'h00, 8'hFF, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h00, 8'h00, 8'h05, 8'h00, 8'hFF, 1'b1}, 1'b0, NO_RESULT},
        '{'{8'h00, 8'h00, 8'h35, 8'h10, 8'h07, 1'b1}, 1'b0, NO_RESULT}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_index = CFG_GUARD;
    t_hz       cfg_data  = '0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // predictor copy of the two registers
    t_hz guard_cfg     = GUARD_RESET;
    t_hz agc_limit_cfg = AGC_LIMIT_RESET;

    t_out_item profile_q[$];

    int  errors        = 0;
    int  presets_sent  = 0;
    int  results_seen  = 0;
    int  sender_held   = 0;
    int  settings_used = 1;
    int  cycle_count   = 0;
    int  status_seen [4];
    bit  calm          = 1'b0;
    int  hold_left     = 0;

    radio_bandwidth_profile_select i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_item      (in_item),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_item      (out_item)
    );

    always #5ns clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // filter bandwidth for an exponent and mantissa, truncated
    function automatic t_hz filter_bw(logic [1:0] bw_exp, logic [1:0] bw_mant);
        return 20'(64'(XTAL_HZ) / ((64'd8 * (64'd4 + 64'(bw_mant))) << bw_exp));
    endfunction

    function automatic t_out_item predict_profile(t_in_item it);
        t_out_item   res;
        logic [2:0]  fmt;
        logic [63:0] prod;
        logic [31:0] need;
        t_hz         pick_bw;
        t_hz         cand;
        logic [3:0]  pick_code;
        bit          found;
        int          code;
        fmt                 = it.modem_cfg2[6:4];
        res.profile_status  = ST_KEPT;
        res.new_modem_cfg4  = it.modem_cfg4;
        res.new_agc_ctrl2   = it.agc_ctrl2;
        res.rx_filter_hz    = filter_bw(it.modem_cfg4[7:6], it.modem_cfg4[5:4]);
        res.data_rate_hz    = '0;
        res.deviation_hz    = '0;
        if (fmt == FMT_OOK) begin
            res.profile_status  = ST_OOK;
            res.new_modem_cfg4  = {FILTER_OOK_CODE, it.modem_cfg4[3:0]};
            res.new_agc_ctrl2   = AGC_OOK_VALUE;
            res.rx_filter_hz    = filter_bw(FILTER_OOK_CODE[3:2], FILTER_OOK_CODE[1:0]);
        end else if (fmt == FMT_2FSK || fmt == FMT_GFSK) begin
            // data rate: (256 + mantissa) * 2^exp * xtal / 2^28, rounded
            prod = (64'd256 + 64'(it.modem_cfg3)) << it.modem_cfg4[3:0];
            prod = prod * 64'(XTAL_HZ);
            res.data_rate_hz = 21'((prod + (64'd1 << 27)) >> 28);
            // deviation: xtal * (8 + mantissa) * 2^exp / 2^17, rounded
            prod = (64'(XTAL_HZ) * (64'd8 + 64'(it.deviation_reg[2:0])))
                   << it.deviation_reg[6:4];
            res.deviation_hz = 19'((prod + 64'd65536) >> 17);
            need = 32'(res.data_rate_hz) + 32'(res.deviation_hz) * 2 + 32'(guard_cfg);
            // narrowest code first, widest as the fallback
            pick_code = 4'd0;
            pick_bw   = filter_bw(2'd0, 2'd0);
            found     = 1'b0;
            for (code = 15; code >= 0 && !found; code--) begin
                cand = filter_bw(2'(code >> 2), 2'(code));
                if (32'(cand) >= need) begin
                    pick_code = 4'(code);
                    pick_bw   = cand;
                    found     = 1'b1;
                end
            end
            if (pick_bw >= res.rx_filter_hz) begin
                res.profile_status = ST_SUITABLE;
            end else begin
                res.profile_status  = ST_NARROWED;
                res.new_modem_cfg4  = {pick_code, it.modem_cfg4[3:0]};
                res.rx_filter_hz    = pick_bw;
                if (it.agc_present && pick_bw <= agc_limit_cfg) begin
                    res.new_agc_ctrl2 = (it.agc_ctrl2 & AGC_KEEP_MASK) | AGC_TIGHT_BITS;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly fm presets with random content, some ook and odd formats
    function automatic t_in_item random_preset();
        t_in_item it;
        int       sel;
        it  = t_in_item'(41'({$urandom, $urandom}));
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            it.modem_cfg2[6:4] = FMT_2FSK;
        end else if (sel < 70) begin
            it.modem_cfg2[6:4] = FMT_GFSK;
        end else if (sel < 82) begin
            it.modem_cfg2[6:4] = FMT_OOK;
        end
        // wide filters and slow rates give more narrowing
        if ($urandom_range(0, 1)) begin
            it.modem_cfg4[7:6] = 2'd0;
        end
        if ($urandom_range(0, 2) == 0) begin
            it.modem_cfg4[3:0] = 4'($urandom_range(0, 7));
        end
        return it;
    endfunction

    // idle cycles before the next transfer: mostly none, a few long
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // offer one preset at the falling edge and hold it until accepted
    task automatic offer_preset(input t_in_item it, input bit typed,
                                input t_out_item typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) begin
                in_item = t_in_item'(41'({$urandom, $urandom}));
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge clk); while (in_stall);
        profile_q.push_back(typed ? typed_res : predict_profile(it));
        presets_sent++;
        @(negedge clk);
    endtask

    // let every outstanding result out, then let the pipe go idle
    task automatic settle();
        in_valid = 1'b0;
        while (profile_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input t_hz value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_GUARD) begin
            guard_cfg = value;
        end else begin
            agc_limit_cfg = value;
        end
    endtask

    task automatic set_profile_limits(input t_hz guard, input t_hz agc_limit);
        write_register(CFG_GUARD, guard);
        write_register(CFG_AGC_LIMIT, agc_limit);
        settings_used++;
    endtask

    function automatic void check_field(string field_name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, field_name, want, got);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, plus a long hold when asked for
    // ------------------------------------------------------------------
    initial begin : result_sink
        int run;
        int r;
        run = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                // long hold so the block fills and pushes back on the sender
                out_stall = 1'b1;
                hold_left--;
            end else if (calm || !rst_n) begin
                out_stall = 1'b0;
            end else if (run > 0) begin
                run--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    out_stall = 1'b0;
                    run       = $urandom_range(0, 6);
                end else if (r < 92) begin
                    out_stall = 1'b1;
                    run       = $urandom_range(0, 2);
                end else begin
                    out_stall = 1'b1;
                    run       = $urandom_range(8, 40);
                end
            end
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && in_valid && in_stall) begin
            sender_held++;
        end
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (profile_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: unexpected transfer, expected none, got %p",
                             $time, out_item);
                end
            end else begin
                want = profile_q.pop_front();
                check_field("profile_status", want.profile_status, out_item.profile_status);
                check_field("new_modem_cfg4", want.new_modem_cfg4, out_item.new_modem_cfg4);
                check_field("new_agc_ctrl2", want.new_agc_ctrl2, out_item.new_agc_ctrl2);
                check_field("rx_filter_hz", want.rx_filter_hz, out_item.rx_filter_hz);
                check_field("data_rate_hz", want.data_rate_hz, out_item.data_rate_hz);
                check_field("deviation_hz", want.deviation_hz, out_item.deviation_hz);
                status_seen[want.profile_status]++;
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, profile_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table under the reset register values
        foreach (DIR_TABLE[row]) begin
            offer_preset(DIR_TABLE[row].stim, DIR_TABLE[row].typed, DIR_TABLE[row].result);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                1: set_profile_limits(20'd0, 20'd812500);
                2: set_profile_limits(20'd1000000, 20'd0);
                3: set_profile_limits(20'hFFFFF, 20'hFFFFF);
                4: set_profile_limits(t_hz'($urandom_range(0, 200000)),
                                      t_hz'($urandom_range(0, 812500)));
                5: set_profile_limits(t_hz'($urandom), t_hz'($urandom));
                default: ;
            endcase
            // one phase runs flat out with no gaps and no stalls
            calm = (ph == 3);
            if (ph == 2 || ph == 4) begin
                hold_left = HOLD_CYCLES;
            end
            repeat (PRESETS_PER_PHASE) begin
                offer_preset(random_preset(), 1'b0, NO_RESULT);
            end
        end
        settle();

        $display("covered %0d presets and %0d results under %0d register settings",
                 presets_sent, results_seen, settings_used);
        $display("%0d narrowed, %0d suitable, %0d on-off keying, %0d kept; held off %0d cycles",
                 status_seen[ST_NARROWED], status_seen[ST_SUITABLE],
                 status_seen[ST_OOK], status_seen[ST_KEPT], sender_held);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
design/rbps_pkg.sv
design/radio_bandwidth_profile_select.sv
tb/tb_top.sv
